@@ src/dtpc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtpc_pkg
// Shared widths, beat types and helpers for the directed two-path counter.
// ----------------------------------------------------------------------------
package dtpc_pkg;

  localparam int unsigned VERTEX_W         = 10;
  localparam int unsigned BATCH_W          = 24;
  localparam int unsigned COUNT_W          = 64;
  localparam int unsigned EDGE_CNT_W       = 32;
  localparam int unsigned DEG_W            = 32;
  localparam int unsigned DELTA_W          = DEG_W + 1;
  localparam int unsigned DEF_NUM_VERTICES = 1024;

  localparam logic [BATCH_W-1:0] BATCH_SIZE_RESET = BATCH_W'(10000);

  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned PIPE_DEPTH = 4;
  localparam int unsigned INFLIGHT_W = $clog2(PIPE_DEPTH + 1);
  localparam int unsigned OCC_W      = $clog2(FIFO_DEPTH + PIPE_DEPTH + 1);

  typedef struct packed {
    logic [VERTEX_W-1:0] src_vertex;
    logic [VERTEX_W-1:0] dst_vertex;
    logic                last_edge;
  } dtpc_edge_t;

  typedef struct packed {
    logic [COUNT_W-1:0]    path_count;
    logic [EDGE_CNT_W-1:0] edges_seen;
    logic                  is_final;
  } dtpc_report_t;

  typedef struct packed {
    logic               valid;
    logic [DELTA_W-1:0] delta;
    logic               last;
  } dtpc_delta_t;

  function automatic logic [DEG_W-1:0] deg_sat_inc(input logic [DEG_W-1:0] a);
    deg_sat_inc = (a == '1) ? a : a + DEG_W'(1);
  endfunction

endpackage
`default_nettype wire

@@ src/dtpc_vertex_mod.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtpc_vertex_mod
// Two-stage reduction of source and destination vertex numbers modulo the
// vertex count, by reciprocal multiply and back-multiply.
// ----------------------------------------------------------------------------
module dtpc_vertex_mod import dtpc_pkg::*; #(
  parameter int unsigned NUM_VERTICES = DEF_NUM_VERTICES,
  localparam int unsigned AW = $clog2(NUM_VERTICES)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          edge_valid,
  input  wire dtpc_edge_t    edge_in,
  output logic               addr_valid,
  output logic [AW-1:0]      src_addr,
  output logic [AW-1:0]      dst_addr,
  output logic               addr_last
);

  localparam int unsigned VW     = VERTEX_W;
  localparam bit          REDUCE = (NUM_VERTICES < (1 << VW));
  localparam int unsigned KS     = 2 * VW;
  localparam logic [KS-1:0] RECIP = KS'(((1 << KS) + NUM_VERTICES - 1) / NUM_VERTICES);
  localparam logic [VW-1:0] NV    = VW'(NUM_VERTICES);

  logic               valid1;
  logic               last1;
  logic [1:0][VW-1:0] vin;
  logic [1:0][AW-1:0] addr_w;

  assign vin[0]   = edge_in.src_vertex;
  assign vin[1]   = edge_in.dst_vertex;
  assign src_addr = addr_w[0];
  assign dst_addr = addr_w[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1     <= 1'b0;
      addr_valid <= 1'b0;
    end else begin
      valid1     <= edge_valid;
      addr_valid <= valid1;
    end
    last1     <= edge_in.last_edge;
    addr_last <= last1;
  end

  for (genvar lane = 0; lane < 2; lane++) begin : g_lane
    logic [VW-1:0] v1;
    logic [AW-1:0] addr_q;

    assign addr_w[lane] = addr_q;

    always_ff @(posedge clk) begin
      v1 <= vin[lane];
    end

    if (REDUCE) begin : g_reduce
      logic [VW+KS-1:0] prod;
      logic [VW-1:0]    q1;
      logic [VW-1:0]    qn;
      logic [VW-1:0]    rem;

      assign prod = {{KS{1'b0}}, vin[lane]} * {{VW{1'b0}}, RECIP};
      assign qn   = q1 * NV;
      assign rem  = v1 - qn;

      always_ff @(posedge clk) begin
        q1     <= prod[VW+KS-1:KS];
        addr_q <= rem[AW-1:0];
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        addr_q <= AW'(v1);
      end
    end
  end

endmodule
`default_nettype wire

@@ src/dtpc_degree_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtpc_degree_ram
// Degree memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module dtpc_degree_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr_a,
  input  wire logic [AW-1:0] raddr_b,
  output logic      [DW-1:0] rdata_a,
  output logic      [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

@@ src/dtpc_degree_update.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtpc_degree_update
// Read-modify-write of the in- and out-degree memories with one level of
// write forwarding, the clearing sweep after reset, and the path delta.
// ----------------------------------------------------------------------------
module dtpc_degree_update import dtpc_pkg::*; #(
  parameter int unsigned NUM_VERTICES = DEF_NUM_VERTICES,
  localparam int unsigned AW = $clog2(NUM_VERTICES)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          addr_valid,
  input  wire logic [AW-1:0] src_addr,
  input  wire logic [AW-1:0] dst_addr,
  input  wire logic          addr_last,
  output logic               clearing,
  output dtpc_delta_t        beat
);

  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_VERTICES - 1);

  logic              valid3;
  logic [AW-1:0]     s3;
  logic [AW-1:0]     d3;
  logic              last3;
  logic [AW-1:0]     clr_addr;

  logic [DEG_W-1:0]  in_rd_s;
  logic [DEG_W-1:0]  in_rd_d;
  logic [DEG_W-1:0]  out_rd_d;
  logic [DEG_W-1:0]  out_rd_s;

  logic              in_lw_valid;
  logic [AW-1:0]     in_lw_addr;
  logic [DEG_W-1:0]  in_lw_data;
  logic              out_lw_valid;
  logic [AW-1:0]     out_lw_addr;
  logic [DEG_W-1:0]  out_lw_data;

  logic [DEG_W-1:0]  in_s;
  logic [DEG_W-1:0]  in_d;
  logic [DEG_W-1:0]  out_d;
  logic [DEG_W-1:0]  out_s;
  logic [DEG_W-1:0]  in_inc;
  logic [DEG_W-1:0]  out_inc;
  logic [DELTA_W-1:0] delta;

  logic              we;
  logic [AW-1:0]     in_waddr;
  logic [AW-1:0]     out_waddr;
  logic [DEG_W-1:0]  in_wdata;
  logic [DEG_W-1:0]  out_wdata;

  // forwarding from the previous cycle's write
  always_comb begin
    in_s  = (in_lw_valid  && in_lw_addr  == s3) ? in_lw_data  : in_rd_s;
    in_d  = (in_lw_valid  && in_lw_addr  == d3) ? in_lw_data  : in_rd_d;
    out_d = (out_lw_valid && out_lw_addr == d3) ? out_lw_data : out_rd_d;
    out_s = (out_lw_valid && out_lw_addr == s3) ? out_lw_data : out_rd_s;
    in_inc  = deg_sat_inc(in_d);
    out_inc = deg_sat_inc(out_s);
    delta   = {1'b0, in_s} + {1'b0, out_d} + DELTA_W'(s3 == d3);
  end

  assign we        = clearing || valid3;
  assign in_waddr  = clearing ? clr_addr : d3;
  assign out_waddr = clearing ? clr_addr : s3;
  assign in_wdata  = clearing ? '0 : in_inc;
  assign out_wdata = clearing ? '0 : out_inc;

  dtpc_degree_ram #(
    .DEPTH (NUM_VERTICES),
    .AW    (AW),
    .DW    (DEG_W)
  ) u_in_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (in_waddr),
    .wdata   (in_wdata),
    .raddr_a (src_addr),
    .raddr_b (dst_addr),
    .rdata_a (in_rd_s),
    .rdata_b (in_rd_d)
  );

  dtpc_degree_ram #(
    .DEPTH (NUM_VERTICES),
    .AW    (AW),
    .DW    (DEG_W)
  ) u_out_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (out_waddr),
    .wdata   (out_wdata),
    .raddr_a (dst_addr),
    .raddr_b (src_addr),
    .rdata_a (out_rd_d),
    .rdata_b (out_rd_s)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing     <= 1'b1;
      clr_addr     <= '0;
      valid3       <= 1'b0;
      in_lw_valid  <= 1'b0;
      out_lw_valid <= 1'b0;
      beat.valid   <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == LAST_ADDR) begin
          clearing <= 1'b0;
        end
      end
      valid3       <= addr_valid;
      in_lw_valid  <= valid3;
      out_lw_valid <= valid3;
      beat.valid   <= valid3;
    end
    s3          <= src_addr;
    d3          <= dst_addr;
    last3       <= addr_last;
    in_lw_addr  <= d3;
    in_lw_data  <= in_inc;
    out_lw_addr <= s3;
    out_lw_data <= out_inc;
    beat.delta  <= delta;
    beat.last   <= last3;
  end

endmodule
`default_nettype wire

@@ src/dtpc_report.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtpc_report
// Saturating path total, edge and batch counters, batch size register and
// the report queue.
// ----------------------------------------------------------------------------
module dtpc_report import dtpc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dtpc_delta_t           beat,
  input  wire logic                  cfg_we,
  input  wire logic [BATCH_W-1:0]    cfg_data,
  output logic                       report_valid,
  input  wire logic                  report_ready,
  output dtpc_report_t               report_data,
  output logic [FIFO_CNT_W-1:0]      fifo_count
);

  logic [BATCH_W-1:0]    batch_size;
  logic [COUNT_W-1:0]    total;
  logic [BATCH_W-1:0]    fill;
  logic [EDGE_CNT_W-1:0] edges;

  logic [BATCH_W-1:0]    limit;
  logic [BATCH_W-1:0]    fill_inc;
  logic [COUNT_W:0]      sum;
  logic [COUNT_W-1:0]    total_next;
  logic [EDGE_CNT_W-1:0] edges_next;
  logic                  hit;

  dtpc_report_t          fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0]    wr_ptr;
  logic [FIFO_AW-1:0]    rd_ptr;
  logic                  pop;

  always_comb begin
    limit      = (batch_size == '0) ? BATCH_W'(1) : batch_size;
    fill_inc   = fill + BATCH_W'(1);
    sum        = {1'b0, total} + {{(COUNT_W + 1 - DELTA_W){1'b0}}, beat.delta};
    total_next = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
    edges_next = (edges == '1) ? edges : edges + EDGE_CNT_W'(1);
    hit        = beat.valid && (fill_inc >= limit || beat.last);
  end

  assign report_valid = (fifo_count != '0);
  assign report_data  = fifo[rd_ptr];
  assign pop          = report_valid && report_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_size <= BATCH_SIZE_RESET;
      total      <= '0;
      fill       <= '0;
      edges      <= '0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (cfg_we) begin
        batch_size <= cfg_data;
      end
      if (beat.valid) begin
        total <= total_next;
        edges <= edges_next;
        fill  <= hit ? '0 : fill_inc;
      end
      if (hit) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      if (hit && !pop) begin
        fifo_count <= fifo_count + FIFO_CNT_W'(1);
      end else if (pop && !hit) begin
        fifo_count <= fifo_count - FIFO_CNT_W'(1);
      end
    end
    if (hit) begin
      fifo[wr_ptr] <= '{path_count: total_next, edges_seen: edges_next,
                        is_final: beat.last};
    end
  end

endmodule
`default_nettype wire

@@ src/directed_two_path_counter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// directed_two_path_counter
// Streaming count of directed 2-paths over per-vertex in/out degrees kept in
// two memories, with a report every batch of edges or at a last edge.
//
//   channel   signals                              beat
//   -------   ----------------------------------   ------------------------
//   edge      edge_valid / edge_ready / edge_data   src, dst, last flag
//   report    report_valid / report_ready / ...     path count, edges, final
//   cfg       cfg_valid / cfg_ready / cfg_data      batch size (24 bit)
//
// One edge per cycle while edge_ready is high. After reset both degree memories
// are swept to zero, one entry per cycle, with edge_ready low until the sweep
// ends; cfg writes are taken throughout. The degree pipeline never stalls:
// edge_ready drops when edges in flight plus queued reports reach the 8-entry
// report queue.
// ----------------------------------------------------------------------------
module directed_two_path_counter import dtpc_pkg::*; #(
  parameter int unsigned NUM_VERTICES = DEF_NUM_VERTICES
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                edge_valid,
  output logic                     edge_ready,
  input  wire dtpc_edge_t          edge_data,
  output logic                     report_valid,
  input  wire logic                report_ready,
  output dtpc_report_t             report_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [BATCH_W-1:0]  cfg_data
);

  localparam int unsigned AW = $clog2(NUM_VERTICES);

  logic                  accept;
  logic                  addr_valid;
  logic [AW-1:0]         src_addr;
  logic [AW-1:0]         dst_addr;
  logic                  addr_last;
  logic                  clearing;
  dtpc_delta_t           beat;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [INFLIGHT_W-1:0] inflight;
  logic [OCC_W-1:0]      occupancy;

  assign cfg_ready  = 1'b1;
  assign occupancy  = OCC_W'(inflight) + OCC_W'(fifo_count);
  assign edge_ready = !clearing && (occupancy < OCC_W'(FIFO_DEPTH));
  assign accept     = edge_valid && edge_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (accept && !beat.valid) begin
      inflight <= inflight + INFLIGHT_W'(1);
    end else if (beat.valid && !accept) begin
      inflight <= inflight - INFLIGHT_W'(1);
    end
  end

  dtpc_vertex_mod #(
    .NUM_VERTICES (NUM_VERTICES)
  ) u_vertex_mod (
    .clk        (clk),
    .rst        (rst),
    .edge_valid (accept),
    .edge_in    (edge_data),
    .addr_valid (addr_valid),
    .src_addr   (src_addr),
    .dst_addr   (dst_addr),
    .addr_last  (addr_last)
  );

  dtpc_degree_update #(
    .NUM_VERTICES (NUM_VERTICES)
  ) u_degree_update (
    .clk        (clk),
    .rst        (rst),
    .addr_valid (addr_valid),
    .src_addr   (src_addr),
    .dst_addr   (dst_addr),
    .addr_last  (addr_last),
    .clearing   (clearing),
    .beat       (beat)
  );

  dtpc_report u_report (
    .clk          (clk),
    .rst          (rst),
    .beat         (beat),
    .cfg_we       (cfg_valid),
    .cfg_data     (cfg_data),
    .report_valid (report_valid),
    .report_ready (report_ready),
    .report_data  (report_data),
    .fifo_count   (fifo_count)
  );

endmodule
`default_nettype wire
